@@ hw/rtl/ahdsr_pkg.sv @@
`default_nettype none

package ahdsr_pkg;

  // fixed point format of levels and coefficients
  localparam int unsigned FracBits = 16;
  localparam int unsigned LevelW   = FracBits + 1;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned HoldCntW = 25;
  localparam int unsigned HoldMaxW = 24;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // default for the hold frame counter width
  localparam int unsigned HoldBitsDef = 24;

  // unity and the attack target (1.1 rounded)
  localparam logic [LevelW-1:0] OneQ    = LevelW'(64'd1 << FracBits);
  localparam logic [LevelW-1:0] TargetQ = LevelW'(((64'd1 << FracBits) * 64'd11 + 64'd5) / 64'd10);

  typedef enum logic [2:0] {
    ST_ATTACK  = 3'd0,
    ST_HOLD    = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TRIGGER = 2'd1,
    EV_RELEASE = 2'd2,
    EV_CLEAR   = 2'd3
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATTACK_COEF   = 3'd0,
    CFG_HOLD_FRAMES   = 3'd1,
    CFG_DECAY_COEF    = 3'd2,
    CFG_SUSTAIN_LEVEL = 3'd3,
    CFG_RELEASE_COEF  = 3'd4
  } cfg_idx_e;

  // envelope state carried from sample to sample
  typedef struct packed {
    stage_e                stage;
    logic [LevelW-1:0]     level;
    logic [HoldCntW-1:0]   hold_cnt;
  } env_state_t;

  // settings seen by the step logic
  typedef struct packed {
    logic [CoefW-1:0]      attack_coef;
    logic [HoldMaxW-1:0]   hold_frames;
    logic [CoefW-1:0]      decay_coef;
    logic [LevelW-1:0]     sustain_level;
    logic [CoefW-1:0]      release_coef;
  } env_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/ahdsr_envelope_generator.sv @@
// path: each accepted sample passes the input register, one pass of the step logic
//   with a single shared one-pole unit (two multiplies and an add), and the result register
// throughput: one sample per cycle while the output is not stalled
// reset: asynchronous, active low; stage goes to release, level and hold count to zero,
//   coefficients and hold frames to zero, sustain level to unity
`default_nettype none

module ahdsr_envelope_generator #(
  parameter int unsigned HoldBits = ahdsr_pkg::HoldBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [ahdsr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ahdsr_pkg::CfgDataW-1:0]  cfg_data_i,
  // sample ticks
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      event_req_i,
  // envelope levels
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ahdsr_pkg::LevelW-1:0]    level_o,
  output logic [2:0]                      stage_o
);
  import ahdsr_pkg::*;

  localparam int unsigned HfW = (HoldBits < HoldMaxW) ? HoldBits : HoldMaxW;

  logic [CoefW-1:0]   attack_coef_q;
  logic [HfW-1:0]     hold_frames_q;
  logic [CoefW-1:0]   decay_coef_q;
  logic [LevelW-1:0]  sustain_level_q;
  logic [CoefW-1:0]   release_coef_q;
  logic [CoefW-1:0]   cfg_coef;
  logic [LevelW-1:0]  cfg_sustain;
  env_cfg_t           cfg;

  logic               in_valid_q;
  event_e             event_q;
  logic               in_acc;
  logic               fire;

  env_state_t         state_q;
  env_state_t         state_d;

  logic               out_valid_q;
  logic [LevelW-1:0]  level_q;
  stage_e             stage_q;

  // coefficient and sustain saturation
  always_comb begin
    cfg_coef    = cfg_data_i[CoefW-1:0];
    cfg_sustain = cfg_data_i[LevelW-1:0];
    if (LevelW'(cfg_coef) >= OneQ) begin
      cfg_coef = CoefW'(OneQ - LevelW'(1));
    end
    if (cfg_sustain > OneQ) begin
      cfg_sustain = OneQ;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_coef_q   <= '0;
      hold_frames_q   <= '0;
      decay_coef_q    <= '0;
      sustain_level_q <= OneQ;
      release_coef_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ATTACK_COEF:   attack_coef_q   <= cfg_coef;
        CFG_HOLD_FRAMES:   hold_frames_q   <= cfg_data_i[HfW-1:0];
        CFG_DECAY_COEF:    decay_coef_q    <= cfg_coef;
        CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_sustain;
        CFG_RELEASE_COEF:  release_coef_q  <= cfg_coef;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.attack_coef   = attack_coef_q;
    cfg.hold_frames   = HoldMaxW'(hold_frames_q);
    cfg.decay_coef    = decay_coef_q;
    cfg.sustain_level = sustain_level_q;
    cfg.release_coef  = release_coef_q;
  end

  // handshake: step fires when a sample waits in the input register and the result register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      event_q <= event_e'(event_req_i);
    end
  end

  // one envelope step
  ahdsr_step u_step (
    .cfg_i   (cfg),
    .cur_i   (state_q),
    .event_i (event_q),
    .nxt_o   (state_d)
  );

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage    <= ST_RELEASE;
      state_q.level    <= '0;
      state_q.hold_cnt <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      level_q <= state_d.level;
      stage_q <= state_d.stage;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign stage_o     = 3'(stage_q);

`ifndef SYNTHESIS
  // the input side only stalls while a sample waits in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // a step always leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("step fired without a result");

  // attack never overshoots its target
  a_attack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stage_o == 3'(ST_ATTACK)) |-> (level_o <= TargetQ))
    else $error("attack level above target");

  // a hold result means the hold counter has advanced
  a_hold_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stage_q == ST_HOLD && !in_valid_q) |-> (state_q.hold_cnt != '0))
    else $error("hold stage with zero hold count");

  // the result register follows the envelope state
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fire) |-> (level_q == state_q.level && stage_q == state_q.stage))
    else $error("result register differs from envelope state");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ahdsr_step.sv @@
`default_nettype none

module ahdsr_step (
  input  ahdsr_pkg::env_cfg_t   cfg_i,
  input  ahdsr_pkg::env_state_t cur_i,
  input  ahdsr_pkg::event_e     event_i,
  output ahdsr_pkg::env_state_t nxt_o
);
  import ahdsr_pkg::*;

  localparam int unsigned ProdW = LevelW + FracBits + 2;

  stage_e              stg;
  logic [LevelW-1:0]   lvl;
  logic [HoldCntW-1:0] hc;
  logic                done;
  logic                stay;
  logic                op_en;
  logic [CoefW-1:0]    coef;
  logic [LevelW-1:0]   target;
  logic [LevelW-1:0]   inv_coef;
  logic [ProdW-1:0]    prod_lvl;
  logic [ProdW-1:0]    prod_tgt;
  logic [ProdW-1:0]    sum;
  logic [LevelW-1:0]   op_level;

  // next stage: apply the event, then fall through finished stages
  always_comb begin
    stg    = cur_i.stage;
    lvl    = cur_i.level;
    hc     = cur_i.hold_cnt;
    done   = 1'b0;
    stay   = 1'b0;
    op_en  = 1'b0;
    coef   = cfg_i.release_coef;
    target = '0;

    case (event_i)
      EV_TRIGGER: stg = ST_ATTACK;
      EV_RELEASE: stg = ST_RELEASE;
      EV_CLEAR: begin
        stg = ST_RELEASE;
        lvl = '0;
      end
      default: ;
    endcase

    // attack until unity is reached
    if (stg == ST_ATTACK) begin
      if (lvl < OneQ) begin
        op_en  = 1'b1;
        coef   = cfg_i.attack_coef;
        target = TargetQ;
        done   = 1'b1;
      end else begin
        stg = ST_HOLD;
        hc  = '0;
      end
    end

    // hold counts every hold sample, also the one that leaves
    if (!done && stg == ST_HOLD) begin
      stay = hc < HoldCntW'(cfg_i.hold_frames);
      hc   = hc + HoldCntW'(1);
      if (stay) begin
        done = 1'b1;
      end else begin
        stg = ST_DECAY;
      end
    end

    // decay while above the sustain level
    if (!done && stg == ST_DECAY) begin
      if (lvl > cfg_i.sustain_level) begin
        op_en  = 1'b1;
        coef   = cfg_i.decay_coef;
        target = cfg_i.sustain_level;
        done   = 1'b1;
      end else begin
        stg = ST_SUSTAIN;
      end
    end

    // sustain keeps filtering, release scales toward zero
    if (!done) begin
      op_en = 1'b1;
      if (stg == ST_SUSTAIN) begin
        coef   = cfg_i.decay_coef;
        target = cfg_i.sustain_level;
      end else begin
        stg    = ST_RELEASE;
        coef   = cfg_i.release_coef;
        target = '0;
      end
    end
  end

  // shared one-pole unit, release is the case of a zero target
  assign inv_coef = OneQ - LevelW'(coef);
  assign prod_lvl = ProdW'(coef) * ProdW'(lvl);
  assign prod_tgt = ProdW'(inv_coef) * ProdW'(target);
  assign sum      = prod_lvl + prod_tgt;
  assign op_level = sum[FracBits +: LevelW];

  // next state
  always_comb begin
    nxt_o.stage    = stg;
    nxt_o.level    = op_en ? op_level : lvl;
    nxt_o.hold_cnt = hc;
  end

endmodule

`default_nettype wire

@@ verif/ahdsr_envelope_generator_tb.sv @@
`default_nettype none

module ahdsr_envelope_generator_tb;
  import ahdsr_pkg::*;

  // fixed point constants at full precision
  localparam logic [63:0] UnityQ      = 64'd1 << FracBits;
  localparam logic [63:0] AttackGoalQ = (UnityQ * 64'd11 + 64'd5) / 64'd10;
  localparam logic [63:0] LevelMask   = (64'd1 << LevelW) - 64'd1;

  // run control
  localparam int unsigned CycleLimit     = 600000;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned RandomPhases   = 10;
  localparam int unsigned ExtremeItems   = 40;
  localparam int unsigned PhaseItems     = 72;
  localparam int unsigned MaxPrinted     = 100;
  localparam int unsigned FirstUnusedIdx = int'(CFG_RELEASE_COEF) + 1;
  localparam int unsigned LastUnusedIdx  = (1 << CfgIdxW) - 1;

  // one envelope sample as it leaves the block
  typedef struct {
    logic [LevelW-1:0] level;
    stage_e            stage;
  } env_sample_t;

  // envelope predictor and queue of levels still to come out
  class envelope_scoreboard;
    logic [CoefW-1:0]    attack_coef;
    logic [HoldMaxW-1:0] hold_frames;
    logic [CoefW-1:0]    decay_coef;
    logic [LevelW-1:0]   sustain_level;
    logic [CoefW-1:0]    release_coef;
    stage_e              cur_stage;
    logic [63:0]         cur_level;
    logic [HoldCntW-1:0] hold_cnt;
    env_sample_t         expected_levels[$];
    int unsigned         errors;

    function new();
      attack_coef   = '0;
      hold_frames   = '0;
      decay_coef    = '0;
      sustain_level = LevelW'(UnityQ);
      release_coef  = '0;
      cur_stage     = ST_RELEASE;
      cur_level     = '0;
      hold_cnt      = '0;
      errors        = 0;
    endfunction

    // register write as the block sees it; unknown indexes do nothing
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (cfg_idx_e'(idx))
        CFG_ATTACK_COEF:   attack_coef = data[CoefW-1:0];
        CFG_HOLD_FRAMES:   hold_frames = data[HoldMaxW-1:0];
        CFG_DECAY_COEF:    decay_coef = data[CoefW-1:0];
        CFG_SUSTAIN_LEVEL: begin
          if (64'(data[LevelW-1:0]) > UnityQ) sustain_level = LevelW'(UnityQ);
          else sustain_level = data[LevelW-1:0];
        end
        CFG_RELEASE_COEF:  release_coef = data[CoefW-1:0];
        default: ;
      endcase
    endfunction

    // one-pole step toward a goal, truncated
    function logic [63:0] one_pole(logic [63:0] coef, logic [63:0] lvl, logic [63:0] goal);
      return (coef * lvl + (UnityQ - coef) * goal) >> FracBits;
    endfunction

    // apply the event, advance one sample and queue the level it gives
    function void note_tick(event_e ev);
      logic [63:0] sl;
      bit          settled;
      bit          stay;
      env_sample_t smp;
      sl      = 64'(sustain_level);
      settled = 1'b0;
      case (ev)
        EV_TRIGGER: cur_stage = ST_ATTACK;
        EV_RELEASE: cur_stage = ST_RELEASE;
        EV_CLEAR: begin
          cur_stage = ST_RELEASE;
          cur_level = '0;
        end
        default: ;
      endcase
      // attack until unity, then hold starts from a cleared count
      if (cur_stage == ST_ATTACK) begin
        if (cur_level < UnityQ) begin
          cur_level = one_pole(64'(attack_coef), cur_level, AttackGoalQ);
          settled   = 1'b1;
        end else begin
          cur_stage = ST_HOLD;
          hold_cnt  = '0;
        end
      end
      // hold counts every sample, the leaving one too
      if (!settled && cur_stage == ST_HOLD) begin
        stay     = hold_cnt < HoldCntW'(hold_frames);
        hold_cnt = hold_cnt + 1'b1;
        if (stay) settled = 1'b1;
        else cur_stage = ST_DECAY;
      end
      if (!settled && cur_stage == ST_DECAY) begin
        if (cur_level > sl) begin
          cur_level = one_pole(64'(decay_coef), cur_level, sl);
          settled   = 1'b1;
        end else begin
          cur_stage = ST_SUSTAIN;
        end
      end
      if (!settled) begin
        if (cur_stage == ST_SUSTAIN) begin
          cur_level = one_pole(64'(decay_coef), cur_level, sl);
        end else begin
          cur_stage = ST_RELEASE;
          cur_level = (64'(release_coef) * cur_level) >> FracBits;
        end
      end
      cur_level = cur_level & LevelMask;
      smp.level = cur_level[LevelW-1:0];
      smp.stage = cur_stage;
      expected_levels.push_back(smp);
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // compare one output transaction against the oldest predicted sample
    task check_level(logic [LevelW-1:0] level, logic [2:0] stage);
      env_sample_t want;
      if (expected_levels.size() == 0) begin
        report($sformatf("unexpected transaction level %0d stage %0d", level, stage));
        return;
      end
      want = expected_levels.pop_front();
      if (level !== want.level)
        report($sformatf("level %0d, predicted %0d", level, want.level));
      if (stage !== 3'(want.stage))
        report($sformatf("stage %0d, predicted %0d", stage, want.stage));
    endtask

    function int unsigned pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [1:0]          event_req_i = EV_NONE;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LevelW-1:0]   level_o;
  logic [2:0]          stage_o;

  envelope_scoreboard  sb;
  int unsigned         cycles      = 0;
  int unsigned         ticks_sent  = 0;
  int unsigned         in_idle_mode = 1;

  ahdsr_envelope_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .event_req_i (event_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .stage_o     (stage_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_tick(event_e'(event_req_i));
      if (out_valid_o && !out_stall_i) sb.check_level(level_o, stage_o);
    end
  end

  // idle length: mode 0 never idles, mode 2 idles most
  function automatic int unsigned idle_gap(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < ((mode == 1) ? 65 : 35)) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // output back-pressure: short bursts, occasional long ones, quiet stretches
  initial begin : out_stall_gen
    int unsigned busy;
    int unsigned quiet;
    forever begin
      busy  = idle_gap(2);
      quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 4);
      if (busy != 0) begin
        out_stall_i <= 1'b1;
        repeat (busy) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (quiet) @(posedge clk_i);
    end
  end

  // offer one sample tick and wait until it is taken
  task automatic send_tick(event_e ev);
    int unsigned gap;
    gap = idle_gap(in_idle_mode);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    event_req_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  // stop sending and let every predicted sample come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one register write; the enable stays up for the caller to lower
  task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // full register set plus a write to an unused index
  task automatic load_settings(logic [CfgDataW-1:0] atk, logic [CfgDataW-1:0] hld,
                               logic [CfgDataW-1:0] dcy, logic [CfgDataW-1:0] sus,
                               logic [CfgDataW-1:0] rel);
    put_reg(CFG_ATTACK_COEF, atk);
    put_reg(CfgIdxW'($urandom_range(FirstUnusedIdx, LastUnusedIdx)), CfgDataW'($urandom));
    put_reg(CFG_HOLD_FRAMES, hld);
    put_reg(CFG_DECAY_COEF, dcy);
    put_reg(CFG_SUSTAIN_LEVEL, sus);
    put_reg(CFG_RELEASE_COEF, rel);
    cfg_we_i <= 1'b0;
  endtask

  // coefficient with junk in the unused upper bits
  function automatic logic [CfgDataW-1:0] rand_coef();
    int unsigned         r;
    logic [CfgDataW-1:0] data;
    r    = $urandom_range(0, 99);
    data = CfgDataW'($urandom);
    if (r < 8) data[CoefW-1:0] = '0;
    else if (r < 16) data[CoefW-1:0] = '1;
    else data[CoefW-1:0] = CoefW'($urandom_range(16000, 62000));
    return data;
  endfunction

  // sustain gain, sometimes above unity
  function automatic logic [CfgDataW-1:0] rand_sustain();
    int unsigned         r;
    logic [CfgDataW-1:0] data;
    r    = $urandom_range(0, 99);
    data = CfgDataW'($urandom);
    if (r < 10) data[LevelW-1:0] = '0;
    else if (r < 20) data[LevelW-1:0] = LevelW'(UnityQ);
    else if (r < 30) data[LevelW-1:0] = LevelW'($urandom_range(int'(UnityQ) + 1, 131071));
    else data[LevelW-1:0] = LevelW'($urandom_range(20000, int'(UnityQ) - 1));
    return data;
  endfunction

  function automatic logic [CfgDataW-1:0] rand_hold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 90) return CfgDataW'($urandom_range(1, 20));
    return CfgDataW'($urandom_range(100, 600));
  endfunction

  // mostly whole notes with random lengths, some cut short, some noise
  task automatic play_phase(int unsigned n_items);
    int unsigned stop;
    int unsigned r;
    stop = ticks_sent + n_items;
    while (ticks_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_tick(EV_TRIGGER);
        repeat ($urandom_range(2, 90))
          send_tick(($urandom_range(0, 29) == 0) ? EV_TRIGGER : EV_NONE);
        send_tick(EV_RELEASE);
        repeat ($urandom_range(2, 25)) send_tick(EV_NONE);
      end else if (r < 88) begin
        send_tick(EV_TRIGGER);
        repeat ($urandom_range(0, 6)) send_tick(EV_NONE);
        send_tick(($urandom_range(0, 1) == 0) ? EV_CLEAR : EV_RELEASE);
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(event_e'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: instant attack, no hold, sustain at unity, then
    // a retrigger at unity that runs through hold and decay in one sample
    send_tick(EV_NONE);
    send_tick(EV_TRIGGER);
    send_tick(EV_NONE);
    send_tick(EV_NONE);
    send_tick(EV_TRIGGER);
    send_tick(EV_NONE);
    send_tick(EV_RELEASE);
    wait_drained();

    // instant attack, longest hold, every other write saturating or masked
    load_settings('1, '1, '1, '1, '1);
    load_settings('0, '1, '1, '1, '1);
    send_tick(EV_TRIGGER);
    send_tick(EV_NONE);
    send_tick(EV_NONE);
    send_tick(EV_TRIGGER);
    send_tick(EV_RELEASE);
    send_tick(EV_NONE);
    send_tick(EV_CLEAR);
    send_tick(EV_NONE);
    wait_drained();

    // all zero: hold skipped, sustain at zero, release drops to zero
    load_settings('0, '0, '0, '0, '0);
    send_tick(EV_TRIGGER);
    send_tick(EV_NONE);
    send_tick(EV_NONE);
    send_tick(EV_NONE);
    send_tick(EV_TRIGGER);
    send_tick(EV_RELEASE);
    send_tick(EV_NONE);
    wait_drained();

    // random phases, a new setting for each
    for (phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) load_settings('0, '0, '1, '0, '1);
      else if (phase == 1) load_settings('1, '1, '1, CfgDataW'(UnityQ), '1);
      else load_settings(rand_coef(), rand_hold(), rand_coef(), rand_sustain(), rand_coef());
      in_idle_mode = (phase == 2) ? 0 : $urandom_range(0, 2);
      play_phase((phase < 2) ? ExtremeItems : PhaseItems);
      wait_drained();
    end

    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
